FILE: hw/rtl/tftp_block_receiver_defines.svh
// Assertion macros shared by the transfer receiver RTL.
// Depends on nothing; defining ASSERT_OFF turns every check into nothing.
`ifndef TFTP_BLOCK_RECEIVER_DEFINES_SVH
`define TFTP_BLOCK_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define TBR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define TBR_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TBR_ASSERT(name, clk, rst_n, prop, msg)
`define TBR_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

FILE: hw/rtl/tbr_pkg.sv
// Types and codes shared by the transfer receiver front end, back end and top level.
// Depends on nothing.
package tbr_pkg;

  // Event kinds on the input word.
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_PACKET  = 2'd2;

  // Packet opcodes.
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // Actions on the result word.
  localparam logic [1:0] ACT_ACK  = 2'd0;
  localparam logic [1:0] ACT_ERR  = 2'd1;
  localparam logic [1:0] ACT_NONE = 2'd2;

  // Error codes sent in an error packet.
  localparam logic [2:0] ERR_UNDEFINED = 3'd0;
  localparam logic [2:0] ERR_DISK_FULL = 3'd3;

  // Transfer status on the result word.
  localparam logic [1:0] STAT_ACTIVE  = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_ABORTED = 2'd2;

  // Classified command kinds passed from front end to back end.
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_PACKET  = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Retry limit after reset.
  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd5;

  // Depth of the command and result queues.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [9:0]  payload_length;
    logic        store_ok;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] ack_block;
    logic [2:0]  err_code;
    logic [1:0]  status;
  } out_word_t;

  // One classified event waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic        is_data;
    logic        is_error;
    logic [15:0] block_number;
    logic        short_block;
    logic        store_ok;
  } cmd_t;

endpackage

FILE: hw/rtl/tftp_block_receiver.sv
// Stop-and-wait transfer receiver: one event word in, one result word out.
// A pushed word is queued as a command, then executed into the result queue
// and shown on the result ports until popped. Throughput, while neither queue
// is full: one word per cycle; the back end executes one command a cycle.
// Reset (async, active low) empties both queues, sets the phase to idle,
// expects block 1 and loads the retry limit with 5.
module tftp_block_receiver #(
  parameter int unsigned FULL_BLOCK_BYTES = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tbr_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output tbr_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);
  import tbr_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // The retry limit register is always ready for a write.
  assign cfg_ready_o = 1'b1;

  // Front end: accept and classify words.
  tbr_front #(
    .FULL_BLOCK_BYTES(FULL_BLOCK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Back end: transfer state and result queue.
  tbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_word_o  (out_word_o)
  );

`include "tftp_block_receiver_defines.svh"

  // An accepted word is waiting for the back end at the next edge.
  `TBR_ASSERT(a_push_reaches_back, clk_i, rst_ni, push && !full |=> cmd_valid, "accepted word lost")
  // Only an acknowledgement carries a block number.
  `TBR_ASSERT_NEVER(a_ack_block_clear, clk_i, rst_ni, !empty && out_word_o.action != ACT_ACK && out_word_o.ack_block != 16'd0, "ack block set without ack")
  // Only an error packet carries an error code.
  `TBR_ASSERT_NEVER(a_err_code_clear, clk_i, rst_ni, !empty && out_word_o.action != ACT_ERR && out_word_o.err_code != ERR_UNDEFINED, "error code set without error")
  // The status never shows the unused code.
  `TBR_ASSERT_NEVER(a_status_legal, clk_i, rst_ni, !empty && out_word_o.status != STAT_ACTIVE && out_word_o.status != STAT_DONE && out_word_o.status != STAT_ABORTED, "bad status")

endmodule

FILE: hw/rtl/tbr_front.sv
// Front end of the transfer receiver: accepts input words, classifies them and
// queues the resulting commands. Depends on tbr_pkg.
module tbr_front #(
  parameter int unsigned FULL_BLOCK_BYTES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  tbr_pkg::in_word_t in_word_i,
  output logic             cmd_valid_o,
  output tbr_pkg::cmd_t    cmd_o,
  input  logic             cmd_take_i
);
  import tbr_pkg::*;

  localparam logic [16:0] FullBytes = 17'(FULL_BLOCK_BYTES);

  cmd_t              cmd_new;
  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_take;

  // Classify the incoming word; only fields that do not depend on transfer state.
  always_comb begin
    case (in_word_i.func)
      FUNC_START:   cmd_new.kind = CMD_START;
      FUNC_TIMEOUT: cmd_new.kind = CMD_TIMEOUT;
      FUNC_PACKET:  cmd_new.kind = CMD_PACKET;
      default:      cmd_new.kind = CMD_NONE;
    endcase
    cmd_new.is_data      = (in_word_i.opcode == OP_DATA);
    cmd_new.is_error     = (in_word_i.opcode == OP_ERROR);
    cmd_new.block_number = in_word_i.block_number;
    cmd_new.short_block  = ({7'd0, in_word_i.payload_length} < FullBytes);
    cmd_new.store_ok     = in_word_i.store_ok;
  end

  assign full_o      = (count_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_take     = cmd_take_i && cmd_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_take) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_take) begin
      count_d = count_q + 1'b1;
    end else if (do_take && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: hw/rtl/tbr_back.sv
// Back end of the transfer receiver: holds the transfer state, executes one
// command per cycle unless the result queue is full and queues the result words. Depends on tbr_pkg.
module tbr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              cmd_valid_i,
  input  tbr_pkg::cmd_t     cmd_i,
  output logic              cmd_take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output tbr_pkg::out_word_t out_word_o
);
  import tbr_pkg::*;

  // Transfer phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ACTIVE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_ABORT  = 2'd3;

  logic [7:0]  limit_q;
  logic [15:0] expected_q, expected_d;
  logic [15:0] acked_q, acked_d;
  logic [7:0]  retry_q, retry_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] prev_block;
  out_word_t   res;

  out_word_t         queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              res_full, do_pop;

  assign res_full   = (count_q == QCNT_W'(QDEPTH));
  assign cmd_take_o = cmd_valid_i && !res_full;
  assign empty_o    = (count_q == '0);
  assign out_word_o = queue_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;
  assign prev_block = expected_q - 16'd1;

  // Execute one command against the transfer state.
  always_comb begin
    expected_d    = expected_q;
    acked_d       = acked_q;
    retry_d       = retry_q;
    phase_d       = phase_q;
    res.action    = ACT_NONE;
    res.ack_block = '0;
    res.err_code  = ERR_UNDEFINED;
    if (cmd_i.kind == CMD_START) begin
      expected_d = 16'd1;
      acked_d    = '0;
      retry_d    = '0;
      phase_d    = PH_ACTIVE;
      res.action = ACT_ACK;
    end else if (phase_q == PH_ACTIVE && cmd_i.kind == CMD_TIMEOUT) begin
      if (retry_q < limit_q) begin
        retry_d       = retry_q + 8'd1;
        res.action    = ACT_ACK;
        res.ack_block = acked_q;
      end else begin
        phase_d = PH_ABORT;
      end
    end else if (phase_q == PH_ACTIVE && cmd_i.kind == CMD_PACKET) begin
      retry_d = '0;
      if (cmd_i.is_data && cmd_i.block_number == prev_block) begin
        // Duplicate of the previous block: acknowledge it again.
        res.action    = ACT_ACK;
        res.ack_block = acked_q;
      end else if (cmd_i.is_data && cmd_i.block_number == expected_q) begin
        if (!cmd_i.store_ok) begin
          res.action   = ACT_ERR;
          res.err_code = ERR_DISK_FULL;
          phase_d      = PH_ABORT;
        end else begin
          acked_d       = cmd_i.block_number;
          res.action    = ACT_ACK;
          res.ack_block = cmd_i.block_number;
          if (cmd_i.short_block) begin
            phase_d = PH_DONE;
          end else begin
            expected_d = expected_q + 16'd1;
          end
        end
      end else if (cmd_i.is_error) begin
        phase_d = PH_ABORT;
      end else begin
        res.action   = ACT_ERR;
        res.err_code = ERR_UNDEFINED;
        phase_d      = PH_ABORT;
      end
    end
    case (phase_d)
      PH_DONE:  res.status = STAT_DONE;
      PH_ABORT: res.status = STAT_ABORTED;
      default:  res.status = STAT_ACTIVE;
    endcase
  end

  // Result queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (cmd_take_o) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (cmd_take_o && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !cmd_take_o) begin
      count_d = count_q - 1'b1;
    end
  end

  // Transfer state, retry limit and queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= RETRY_LIMIT_RESET;
      expected_q <= 16'd1;
      acked_q    <= '0;
      retry_q    <= '0;
      phase_q    <= PH_IDLE;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_take_o) begin
        expected_q <= expected_d;
        acked_q    <= acked_d;
        retry_q    <= retry_d;
        phase_q    <= phase_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

endmodule
